/* sv/flp16_pkg.sv */
package flp16_pkg;

   localparam int MASTER_FRAC = 24;
   localparam int TABLE_LEN = 16;
   localparam int MASTER_BITS = 25;

   // Low-pass coefficient set in Q1.24; the filter uses a rounded copy.
   localparam logic signed [MASTER_BITS-1:0] COEF_Q24 [TABLE_LEN] = '{
      -25'sd55207, -25'sd88307, -25'sd115446, 25'sd0,
      25'sd426492, 25'sd1215877, 25'sd2199929, 25'sd3029900,
      25'sd3355443, 25'sd3029900, 25'sd2199929, 25'sd1215877,
      25'sd426492, 25'sd0, -25'sd115446, -25'sd88307
   };

   // Coefficient n at the given number of fraction bits, rounded to nearest
   // with ties away from zero. Taps past the table have coefficient zero.
   function automatic logic signed [MASTER_BITS-1:0] coef_at(input int n, input int frac);
      int sh;
      logic signed [MASTER_BITS:0] c;
      logic [MASTER_BITS:0] mag;
      logic [MASTER_BITS:0] one;
      sh = MASTER_FRAC - frac;
      one = {{MASTER_BITS{1'b0}}, 1'b1};
      if (n >= TABLE_LEN) begin
         return '0;
      end
      c = (MASTER_BITS + 1)'(COEF_Q24[n[3:0]]);
      mag = (c < 0) ? (MASTER_BITS + 1)'(-c) : (MASTER_BITS + 1)'(c);
      if (sh > 0) begin
         mag = (mag + (one << (sh - 1))) >> sh;
      end
      if (c < 0) begin
         return MASTER_BITS'(-signed'(mag));
      end
      return MASTER_BITS'(mag);
   endfunction

endpackage

/* sv/flp16_cell.sv */
module flp16_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS = 16,
   parameter int ACC_BITS = 36,
   parameter logic signed [COEF_BITS-1:0] COEF = '0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [ACC_BITS-1:0] upstream_sum,
   output logic signed [ACC_BITS-1:0] partial_sum
);

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

   logic signed [PROD_BITS-1:0] product;
   logic signed [ACC_BITS-1:0]  partial_ff;
   logic signed [ACC_BITS-1:0]  partial_in;

   assign product = sample * COEF;

   always_comb begin
      partial_in = partial_ff;
      if (shift_en) begin
         partial_in = ACC_BITS'(product) + upstream_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
      end else begin
         partial_ff <= partial_in;
      end
   end

   assign partial_sum = partial_ff;

endmodule

/* sv/flp16_out.sv */
module flp16_out #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS = 15,
   parameter int ACC_BITS = 36
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc_load,
   input  logic signed [ACC_BITS-1:0]    acc,
   output logic                          acc_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered
);

   localparam int RW = ACC_BITS + 1;
   localparam logic [RW-1:0] HALF = {{(RW - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [RW-1:0] LIM_HI =
      {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [RW-1:0] LIM_LO = ~LIM_HI;

   logic                          acc_valid_ff;
   logic                          acc_valid_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] filtered_ff;
   logic signed [SAMPLE_BITS-1:0] filtered_in;
   logic                          out_free;
   logic                          move;
   logic signed [RW-1:0]          biased;
   logic signed [RW-1:0]          rounded;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign move = acc_valid_ff && out_free;
   assign acc_free = !acc_valid_ff || out_free;

   assign biased = RW'(acc) + signed'(HALF);
   assign rounded = biased >>> FRAC_BITS;

   always_comb begin
      acc_valid_in = acc_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      filtered_in = filtered_ff;
      if (move) begin
         acc_valid_in = 1'b0;
      end
      if (acc_load) begin
         acc_valid_in = 1'b1;
      end
      if (out_free) begin
         rsp_valid_in = move;
         if (rounded > LIM_HI) begin
            filtered_in = LIM_HI[SAMPLE_BITS-1:0];
         end else if (rounded < LIM_LO) begin
            filtered_in = LIM_LO[SAMPLE_BITS-1:0];
         end else begin
            filtered_in = rounded[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      filtered_ff <= filtered_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered = filtered_ff;

   // A new sum may only land in the accumulator once the previous one leaves.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      acc_load |-> acc_free)
      else $error("accumulator overwritten while its sum was still waiting");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      acc_load |=> acc_valid_ff)
      else $error("loaded sum was not marked valid");

   a_move_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("sum moved out without producing a result item");

   a_stall_no_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !move)
      else $error("sum moved into a result register that was still held");

endmodule

/* sv/fir_lowpass_16tap.sv */
// Low-pass FIR filter on a signed sample stream, built as a transposed chain
// of multiply-add cells, one per tap, with constant coefficients. It accepts
// one item per clock cycle; each accepted item gives exactly one result item,
// which lands in the first cell's register, then in the output register when
// free. The rate is set by the cell chain, where every cell performs one
// multiply and one add per item, and the input stalls only while a finished
// sum and a held result both wait on rsp_ready. Sums are exact, rounded half
// up to the sample scale and saturated to the signed sample range.
module fir_lowpass_16tap #(
   parameter int TAPS = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered
);

   localparam int COEF_BITS = COEF_FRAC_BITS + 1;
   localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;

   logic                       accept;
   logic                       acc_free;
   logic signed [ACC_BITS-1:0] chain [TAPS+1];

   assign req_ready = acc_free;
   assign accept = req_valid && acc_free;
   assign chain[TAPS] = '0;

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      flp16_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .COEF_BITS(COEF_BITS),
         .ACC_BITS(ACC_BITS),
         .COEF(COEF_BITS'(flp16_pkg::coef_at(k, COEF_FRAC_BITS)))
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .shift_en(accept),
         .sample(req_sample),
         .upstream_sum(chain[k+1]),
         .partial_sum(chain[k])
      );
   end

   flp16_out #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS(COEF_FRAC_BITS),
      .ACC_BITS(ACC_BITS)
   ) u_out (
      .clock(clock),
      .reset(reset),
      .acc_load(accept),
      .acc(chain[0]),
      .acc_free(acc_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_filtered(rsp_filtered)
   );

endmodule
